@@ sv/iheap_pkg.sv @@
// ----------------------------------------------------------------------------
// iheap_pkg
// Shared types and constants for the indexed min-heap core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package iheap_pkg;

  localparam int unsigned CAPACITY   = 256;
  localparam int unsigned SLOT_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = SLOT_W + 1;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned ITEM_W     = 8;
  localparam int unsigned ITEM_COUNT = 1 << ITEM_W;
  localparam int unsigned ENTRY_W    = KEY_W + ITEM_W;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DECREASE = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_NOP      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_e;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [ITEM_W-1:0]       item;
  } entry_t;

endpackage
`default_nettype wire

@@ sv/indexed_min_heap_core.sv @@
// ----------------------------------------------------------------------------
// indexed_min_heap_core
// Indexed binary min-heap of (signed key, item id) with decrease-key.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: op_i, item_id_i, key_in_i are taken when start_i is high
//   and busy_o is low. Ops: insert, decrease key, remove minimum.
//   Result channel: one word per command, shown for one cycle with valid_o.
//   The receiver cannot stall; results must be taken when valid_o is high.
//   Heap slots live in one RAM, the item-to-slot map in a second RAM; both
//   have a registered read. Present bits are flip-flops.
//   Error cases and the unused op answer in the cycle after start.
//   Sift up works level by level with a parent read, then a compare/write;
//   sift down with left and right child reads, a child compare (skipped
//   without a right child) and a compare/write; both end with a final write.
//   Decrease looks up the item's slot first; remove reads root and last entry.
//   One command is in flight at a time; busy_o covers it.
//   Reset empties the heap and marks every item absent at once; RAM contents
//   are not cleared and need no sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [1:0]                          op_i,
  input  wire logic [iheap_pkg::ITEM_W-1:0]        item_id_i,
  input  wire logic signed [iheap_pkg::KEY_W-1:0]  key_in_i,
  output logic                                     valid_o,
  output logic signed [iheap_pkg::KEY_W-1:0]       out_key_o,
  output logic [iheap_pkg::ITEM_W-1:0]             out_item_o,
  output logic [2:0]                               status_o,
  output logic [iheap_pkg::CNT_W-1:0]              occupancy_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_POS    = 11'b00000000010,
    S_ROOT   = 11'b00000000100,
    S_LAST   = 11'b00000001000,
    S_UP_RD  = 11'b00000010000,
    S_UP_CMP = 11'b00000100000,
    S_DN_RD  = 11'b00001000000,
    S_DN_L   = 11'b00010000000,
    S_DN_R   = 11'b00100000000,
    S_DN_CMP = 11'b01000000000,
    S_FIN    = 11'b10000000000
  } state_e;

  state_e                              state_q, state_d;
  iheap_pkg::entry_t                   mov_q, mov_d;
  iheap_pkg::entry_t                   best_q, best_d;
  logic [iheap_pkg::SLOT_W-1:0]        bslot_q, bslot_d;
  logic [iheap_pkg::SLOT_W-1:0]        hole_q, hole_d;
  logic [iheap_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic [iheap_pkg::ITEM_COUNT-1:0]    pres_q, pres_d;
  logic                                valid_q, valid_d;
  iheap_pkg::entry_t                   res_q, res_d;
  iheap_pkg::status_e                  stat_q, stat_d;

  logic                                heap_we;
  logic [iheap_pkg::SLOT_W-1:0]        heap_waddr, heap_raddr;
  iheap_pkg::entry_t                   heap_wdata, heap_rdata;
  logic                                pos_we;
  logic [iheap_pkg::ITEM_W-1:0]        pos_waddr;
  logic [iheap_pkg::SLOT_W-1:0]        pos_wdata, pos_rdata;

  logic [iheap_pkg::CNT_W-1:0]         lchild;
  logic [iheap_pkg::CNT_W:0]           rchild;
  logic [iheap_pkg::SLOT_W-1:0]        parent;

  assign lchild = {hole_q, 1'b1};
  assign rchild = {1'b0, lchild} + {{iheap_pkg::CNT_W{1'b0}}, 1'b1};
  assign parent = (hole_q - {{(iheap_pkg::SLOT_W-1){1'b0}}, 1'b1}) >> 1;

  iheap_ram #(
    .WIDTH(iheap_pkg::ENTRY_W),
    .DEPTH(iheap_pkg::CAPACITY)
  ) u_heap_ram (
    .clk_i  (clk_i),
    .we_i   (heap_we),
    .waddr_i(heap_waddr),
    .wdata_i(heap_wdata),
    .raddr_i(heap_raddr),
    .rdata_o(heap_rdata)
  );

  iheap_ram #(
    .WIDTH(iheap_pkg::SLOT_W),
    .DEPTH(iheap_pkg::ITEM_COUNT)
  ) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (pos_we),
    .waddr_i(pos_waddr),
    .wdata_i(pos_wdata),
    .raddr_i(item_id_i),
    .rdata_o(pos_rdata)
  );

  always_comb begin
    state_d    = state_q;
    mov_d      = mov_q;
    best_d     = best_q;
    bslot_d    = bslot_q;
    hole_d     = hole_q;
    cnt_d      = cnt_q;
    pres_d     = pres_q;
    valid_d    = 1'b0;
    res_d      = res_q;
    stat_d     = stat_q;
    heap_we    = 1'b0;
    heap_waddr = hole_q;
    heap_wdata = mov_q;
    heap_raddr = '0;
    pos_we     = 1'b0;
    pos_waddr  = mov_q.item;
    pos_wdata  = hole_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          mov_d.key  = key_in_i;
          mov_d.item = item_id_i;
          res_d      = '0;
          stat_d     = iheap_pkg::ST_OK;
          case (iheap_pkg::op_e'(op_i))
            iheap_pkg::OP_INSERT: begin
              if (cnt_q == iheap_pkg::CNT_W'(iheap_pkg::CAPACITY)) begin
                stat_d  = iheap_pkg::ST_FULL;
                valid_d = 1'b1;
              end else if (pres_q[item_id_i]) begin
                stat_d  = iheap_pkg::ST_PRESENT;
                valid_d = 1'b1;
              end else begin
                hole_d            = cnt_q[iheap_pkg::SLOT_W-1:0];
                cnt_d             = cnt_q + 1'b1;
                pres_d[item_id_i] = 1'b1;
                state_d           = S_UP_RD;
              end
            end
            iheap_pkg::OP_DECREASE: begin
              if (!pres_q[item_id_i]) begin
                stat_d  = iheap_pkg::ST_ABSENT;
                valid_d = 1'b1;
              end else begin
                state_d = S_POS;
              end
            end
            iheap_pkg::OP_REMOVE: begin
              if (cnt_q == '0) begin
                stat_d  = iheap_pkg::ST_EMPTY;
                valid_d = 1'b1;
              end else begin
                state_d = S_ROOT;
              end
            end
            default: valid_d = 1'b1;
          endcase
        end
      end
      S_POS: begin
        hole_d  = pos_rdata;
        state_d = S_UP_RD;
      end
      S_ROOT: begin
        res_d                   = heap_rdata;
        pres_d[heap_rdata.item] = 1'b0;
        cnt_d                   = cnt_q - 1'b1;
        heap_raddr              = cnt_d[iheap_pkg::SLOT_W-1:0];
        if (cnt_d == '0) begin
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        mov_d   = heap_rdata;
        hole_d  = '0;
        state_d = S_DN_RD;
      end
      S_UP_RD: begin
        heap_raddr = parent;
        state_d    = (hole_q == '0) ? S_FIN : S_UP_CMP;
      end
      S_UP_CMP: begin
        if ($signed(mov_q.key) < $signed(heap_rdata.key)) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          pos_we     = 1'b1;
          pos_waddr  = heap_rdata.item;
          hole_d     = parent;
          state_d    = S_UP_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DN_RD: begin
        heap_raddr = lchild[iheap_pkg::SLOT_W-1:0];
        bslot_d    = lchild[iheap_pkg::SLOT_W-1:0];
        state_d    = (lchild >= cnt_q) ? S_FIN : S_DN_L;
      end
      S_DN_L: begin
        best_d     = heap_rdata;
        heap_raddr = rchild[iheap_pkg::SLOT_W-1:0];
        state_d    = (rchild < {1'b0, cnt_q}) ? S_DN_R : S_DN_CMP;
      end
      S_DN_R: begin
        if ($signed(heap_rdata.key) < $signed(best_q.key)) begin
          best_d  = heap_rdata;
          bslot_d = rchild[iheap_pkg::SLOT_W-1:0];
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if ($signed(mov_q.key) > $signed(best_q.key)) begin
          heap_we    = 1'b1;
          heap_wdata = best_q;
          pos_we     = 1'b1;
          pos_waddr  = best_q.item;
          hole_d     = bslot_q;
          state_d    = S_DN_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pres_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pres_q  <= pres_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mov_q   <= mov_d;
    best_q  <= best_d;
    bslot_q <= bslot_d;
    hole_q  <= hole_d;
    res_q   <= res_d;
    stat_q  <= stat_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign valid_o     = valid_q;
  assign out_key_o   = res_q.key;
  assign out_item_o  = res_q.item;
  assign status_o    = stat_q;
  assign occupancy_o = cnt_q;

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o) else $error("result while busy");
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= iheap_pkg::CNT_W'(iheap_pkg::CAPACITY)) else $error("count overflow");
  a_fin_hole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> ({1'b0, hole_q} < cnt_q)) else $error("hole beyond count");
  a_empty_rm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && op_i == iheap_pkg::OP_REMOVE && cnt_q == '0)
    |=> (valid_o && status_o == iheap_pkg::ST_EMPTY)) else $error("empty remove");

endmodule
`default_nettype wire

@@ sv/iheap_ram.sv @@
// ----------------------------------------------------------------------------
// iheap_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module iheap_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ test/iheap_checker.sv @@
// ----------------------------------------------------------------------------
// iheap_checker
// Tracks the heap contents and the item-to-slot map from accepted command
// words, works out the result word for each command, and compares every
// result word from the core against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module iheap_checker (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic                               busy_i,
  input  wire logic [1:0]                         op_i,
  input  wire logic [iheap_pkg::ITEM_W-1:0]       item_id_i,
  input  wire logic signed [iheap_pkg::KEY_W-1:0] key_in_i,
  input  wire logic                               valid_i,
  input  wire logic signed [iheap_pkg::KEY_W-1:0] out_key_i,
  input  wire logic [iheap_pkg::ITEM_W-1:0]       out_item_i,
  input  wire logic [2:0]                         status_i,
  input  wire logic [iheap_pkg::CNT_W-1:0]        occupancy_i,
  output int                                      fail_count_o,
  output int                                      pending_o
);

  typedef struct packed {
    logic signed [iheap_pkg::KEY_W-1:0] key;
    logic [iheap_pkg::ITEM_W-1:0]       item;
    iheap_pkg::status_e                 status;
    logic [iheap_pkg::CNT_W-1:0]        occupancy;
  } result_t;

  logic signed [iheap_pkg::KEY_W-1:0] heap_key [iheap_pkg::CAPACITY];
  logic [iheap_pkg::ITEM_W-1:0]       heap_item [iheap_pkg::CAPACITY];
  int                                 item_pos [iheap_pkg::ITEM_COUNT];
  logic                               item_in [iheap_pkg::ITEM_COUNT];
  int                                 heap_count;
  result_t                            result_q [$];

  function automatic void swap_entries(int a, int b);
    logic signed [iheap_pkg::KEY_W-1:0] k;
    logic [iheap_pkg::ITEM_W-1:0]       it;
    k = heap_key[a];
    it = heap_item[a];
    heap_key[a] = heap_key[b];
    heap_item[a] = heap_item[b];
    heap_key[b] = k;
    heap_item[b] = it;
    item_pos[heap_item[a]] = a;
    item_pos[heap_item[b]] = b;
  endfunction

  function automatic void bubble_up(int s);
    int p;
    while (s > 0) begin
      p = (s - 1) / 2;
      if (heap_key[s] < heap_key[p]) begin
        swap_entries(s, p);
        s = p;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void bubble_down(int s);
    int c;
    forever begin
      c = 2 * s + 1;
      if (c >= heap_count) break;
      if (c + 1 < heap_count && heap_key[c + 1] < heap_key[c]) c = c + 1;
      if (heap_key[s] > heap_key[c]) begin
        swap_entries(s, c);
        s = c;
      end else begin
        break;
      end
    end
  endfunction

  function automatic result_t heap_command(iheap_pkg::op_e op,
                                           logic [iheap_pkg::ITEM_W-1:0] id,
                                           logic signed [iheap_pkg::KEY_W-1:0] key);
    result_t r;
    int      s;
    r = '0;
    r.status = iheap_pkg::ST_OK;
    case (op)
      iheap_pkg::OP_INSERT: begin
        if (heap_count >= iheap_pkg::CAPACITY) begin
          r.status = iheap_pkg::ST_FULL;
        end else if (item_in[id]) begin
          r.status = iheap_pkg::ST_PRESENT;
        end else begin
          s = heap_count;
          heap_key[s] = key;
          heap_item[s] = id;
          item_pos[id] = s;
          item_in[id] = 1'b1;
          heap_count = heap_count + 1;
          bubble_up(s);
        end
      end
      iheap_pkg::OP_DECREASE: begin
        if (!item_in[id] || item_pos[id] >= heap_count) begin
          r.status = iheap_pkg::ST_ABSENT;
        end else begin
          s = item_pos[id];
          heap_key[s] = key;
          bubble_up(s);
        end
      end
      iheap_pkg::OP_REMOVE: begin
        if (heap_count == 0) begin
          r.status = iheap_pkg::ST_EMPTY;
        end else begin
          r.key = heap_key[0];
          r.item = heap_item[0];
          item_in[heap_item[0]] = 1'b0;
          heap_count = heap_count - 1;
          if (heap_count > 0) begin
            heap_key[0] = heap_key[heap_count];
            heap_item[0] = heap_item[heap_count];
            item_pos[heap_item[0]] = 0;
            bubble_down(0);
          end
        end
      end
      default: ;
    endcase
    r.occupancy = iheap_pkg::CNT_W'(heap_count);
    return r;
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      fail_count_o = 0;
      heap_count = 0;
      for (int i = 0; i < iheap_pkg::ITEM_COUNT; i++) begin
        item_in[i] = 1'b0;
        item_pos[i] = 0;
      end
      result_q.delete();
      pending_o <= 0;
    end else begin
      if (start_i && !busy_i)
        result_q.push_back(heap_command(iheap_pkg::op_e'(op_i), item_id_i, key_in_i));
      if (valid_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: result word with none expected: key %0d item %0d status %0d occ %0d",
                   $time, out_key_i, out_item_i, status_i, occupancy_i);
          fail_count_o++;
        end else begin
          want = result_q.pop_front();
          if (out_key_i !== want.key) begin
            $display("%0t: out_key expected %0d actual %0d", $time, want.key, out_key_i);
            fail_count_o++;
          end
          if (out_item_i !== want.item) begin
            $display("%0t: out_item expected %0d actual %0d", $time, want.item, out_item_i);
            fail_count_o++;
          end
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
            fail_count_o++;
          end
          if (occupancy_i !== want.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
                     occupancy_i);
            fail_count_o++;
          end
        end
      end
      pending_o <= result_q.size();
    end
  end

endmodule
`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for the indexed min-heap core: directed corner commands, then
// random fill, mixed and drain phases sent in bursts with random gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam int NUM_WORDS   = 1950;
  localparam int STALL_LIMIT = 20000;

  logic                               clk;
  logic                               rst_n;
  logic                               start;
  logic                               busy;
  logic [1:0]                         op;
  logic [iheap_pkg::ITEM_W-1:0]       item_id;
  logic signed [iheap_pkg::KEY_W-1:0] key_in;
  logic                               valid;
  logic signed [iheap_pkg::KEY_W-1:0] out_key;
  logic [iheap_pkg::ITEM_W-1:0]       out_item;
  logic [2:0]                         status;
  logic [iheap_pkg::CNT_W-1:0]        occupancy;
  int                                 fail_count;
  int                                 pending;
  int                                 sent;
  int                                 burst_left;
  int                                 quiet_cycles;

  indexed_min_heap_core dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .op_i(op),
    .item_id_i(item_id), .key_in_i(key_in), .valid_o(valid), .out_key_o(out_key),
    .out_item_o(out_item), .status_o(status), .occupancy_o(occupancy)
  );

  iheap_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .op_i(op),
    .item_id_i(item_id), .key_in_i(key_in), .valid_i(valid), .out_key_i(out_key),
    .out_item_i(out_item), .status_i(status), .occupancy_i(occupancy),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [iheap_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(0, 4))
      0: return $signed(32'sd3) - $signed($urandom_range(0, 6));
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [iheap_pkg::ITEM_W-1:0] pick_id(int unsigned hi);
    return iheap_pkg::ITEM_W'($urandom_range(0, hi));
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(iheap_pkg::op_e o, logic [iheap_pkg::ITEM_W-1:0] id,
                           logic signed [iheap_pkg::KEY_W-1:0] k);
    if (burst_left == 0) begin
      start = 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    start = 1'b1;
    op = o;
    item_id = id;
    key_in = k;
    do @(posedge clk); while (busy);
    sent++;
    @(negedge clk);
  endtask

  task automatic fill_phase();
    int order [iheap_pkg::ITEM_COUNT];
    int j;
    int t;
    for (int i = 0; i < iheap_pkg::ITEM_COUNT; i++) order[i] = i;
    for (int i = iheap_pkg::ITEM_COUNT - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < iheap_pkg::ITEM_COUNT; i++)
      send_word(iheap_pkg::OP_INSERT, iheap_pkg::ITEM_W'(order[i]), pick_key());
    repeat (3) send_word(iheap_pkg::OP_INSERT, pick_id(255), pick_key());
    repeat (20) send_word(iheap_pkg::OP_DECREASE, pick_id(255), pick_key());
  endtask

  task automatic mixed_phase(int n);
    int r;
    logic [iheap_pkg::ITEM_W-1:0] id;
    repeat (n) begin
      r = $urandom_range(0, 99);
      id = $urandom_range(0, 1) ? pick_id(15) : pick_id(255);
      if (r < 45) send_word(iheap_pkg::OP_INSERT, id, pick_key());
      else if (r < 70) send_word(iheap_pkg::OP_DECREASE, id, pick_key());
      else if (r < 97) send_word(iheap_pkg::OP_REMOVE, pick_id(255), $urandom());
      else send_word(iheap_pkg::OP_NOP, pick_id(255), $urandom());
    end
  endtask

  task automatic drain_phase();
    repeat ($urandom_range(100, 262))
      send_word(iheap_pkg::OP_REMOVE, pick_id(255), $urandom());
  endtask

  initial begin
    int wait_cycles;
    rst_n = 1'b0;
    start = 1'b0;
    op = iheap_pkg::OP_NOP;
    item_id = '0;
    key_in = '0;
    sent = 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_word(iheap_pkg::OP_REMOVE, 8'd0, 32'sd0);
    send_word(iheap_pkg::OP_NOP, 8'hff, 32'shffffffff);
    send_word(iheap_pkg::OP_INSERT, 8'd0, 32'sh7fffffff);
    send_word(iheap_pkg::OP_INSERT, 8'd255, 32'sh80000000);
    send_word(iheap_pkg::OP_INSERT, 8'd0, 32'sd5);
    send_word(iheap_pkg::OP_INSERT, 8'd1, 32'sd0);
    send_word(iheap_pkg::OP_INSERT, 8'd2, 32'sd0);
    send_word(iheap_pkg::OP_INSERT, 8'd3, 32'sd0);
    send_word(iheap_pkg::OP_DECREASE, 8'd7, 32'sd1);
    send_word(iheap_pkg::OP_DECREASE, 8'd1, -32'sd5);
    send_word(iheap_pkg::OP_DECREASE, 8'd255, 32'sd100);
    send_word(iheap_pkg::OP_DECREASE, 8'd2, 32'sh80000000);
    send_word(iheap_pkg::OP_NOP, 8'd0, 32'sd0);
    repeat (7) send_word(iheap_pkg::OP_REMOVE, 8'd0, 32'sd0);
    send_word(iheap_pkg::OP_DECREASE, 8'd0, 32'sd1);

    fill_phase();
    mixed_phase(150);
    drain_phase();
    while (sent < NUM_WORDS) begin
      case ($urandom_range(0, 5))
        0: fill_phase();
        1: drain_phase();
        default: mixed_phase($urandom_range(50, 200));
      endcase
    end
    start = 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
sv/iheap_pkg.sv
sv/iheap_ram.sv
sv/indexed_min_heap_core.sv
test/iheap_checker.sv
test/tb.sv
